// ----- rtl/shtc_pkg.sv -----
// Package for the stepper homing and traverse controller.
// Holds item layouts, sequencer mode and command codes, and register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package shtc_pkg;

  // Field widths
  localparam int unsigned POS_W = 12;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned CMD_W = 2;

  // Sequencer modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_HOMING  = 2'd1;
  localparam logic [1:0] MODE_OFFSET  = 2'd2;
  localparam logic [1:0] MODE_RUNNING = 2'd3;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CAL  = 2'd2;

  // Register map (byte addresses)
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_LOOP   = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_OFFSET = 3'd4;

  // Register reset values
  localparam logic [POS_W-1:0] LOOP_RESET   = 12'd850;
  localparam logic [POS_W-1:0] OFFSET_RESET = 12'd1200;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Payload of an input request (tdata part, highest field first)
  typedef struct packed {
    logic             switch_seen;
    logic [CNT_W-1:0] step_target;
  } in_data_t;

  // One result item, highest field first
  typedef struct packed {
    logic             calibrating;
    logic             busy_res;
    logic [POS_W-1:0] position;
    logic             direction;
    logic             half_step;
  } result_t;

endpackage : shtc_pkg

`default_nettype wire

// ----- rtl/stepper_homing_traverse_controller_unit.sv -----
// Top level of the stepper homing and traverse controller.
// Uses shtc_pkg for codes, register map and item layouts.
//
// Usage:
//   in_*  : request stream. tuser carries the command (tick, start run,
//           start calibration); tdata carries the step target and the
//           home switch flag.
//   out_* : one result per request: half step pulse, direction, position,
//           busy and calibrating flags.
//   cfg_* : APB-style port; loop length at 0x0, home offset at 0x4.
//           Write only while the stream is idle. pready is tied high.
// Flow: a request taken is registered in the input stage, then evaluated
//   against the sequencer state as it advances into the result register,
//   from which its result is offered until taken.
// Throughput: one request per cycle unless the output stalls. Each
//   request is a single pass of counter increments and compares between
//   the input stage and the result register; the state registers feed back.
// Reset: synchronous, active low; sequencer idle, position zero,
//   direction clockwise, registers back to 850 and 1200.
// Stall: when out_tready is low the result register holds, the input
//   stage fills, and in_tready then drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module stepper_homing_traverse_controller_unit
  import shtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // step_target[15:0], switch_seen[16], zero pad
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // half_step[0], direction[1], position[13:2],
                                       // busy_res[14], calibrating[15]
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Configuration registers
  logic [POS_W-1:0] loop_r;
  logic [POS_W-1:0] offset_cfg_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r       <= LOOP_RESET;
      offset_cfg_r <= OFFSET_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        ADDR_LOOP:   loop_r       <= cfg_pwdata[POS_W-1:0];
        ADDR_OFFSET: offset_cfg_r <= cfg_pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ADDR_LOOP:   cfg_prdata = {{(32-POS_W){1'b0}}, loop_r};
      ADDR_OFFSET: cfg_prdata = {{(32-POS_W){1'b0}}, offset_cfg_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // Input stage
  logic             s1_valid_r;
  logic [CMD_W-1:0] s1_cmd_r;
  in_data_t         s1_data_r;
  logic             adv;
  logic             out_valid_r;
  result_t          out_data_r;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata[CNT_W:0];
    end
  end

  // Sequencer state
  logic [1:0]       mode_r,   mode_nxt;
  logic             dir_r,    dir_nxt;
  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [CNT_W-1:0] steps_r,  steps_nxt;
  logic [CNT_W-1:0] target_r, target_nxt;
  logic             latch_r,  latch_nxt;
  logic [POS_W-1:0] ocnt_r,   ocnt_nxt;
  logic             stepped;
  logic             step_dir;
  logic             sw_l;
  logic [CNT_W-1:0] steps_inc;

  assign sw_l      = latch_r | s1_data_r.switch_seen;
  assign steps_inc = steps_r + 1'b1;

  // Next state for one request
  always_comb begin
    mode_nxt   = mode_r;
    dir_nxt    = dir_r;
    pos_nxt    = pos_r;
    steps_nxt  = steps_r;
    target_nxt = target_r;
    latch_nxt  = latch_r;
    ocnt_nxt   = ocnt_r;
    stepped    = 1'b0;
    step_dir   = dir_r;

    unique case (s1_cmd_r)
      CMD_CAL: begin
        mode_nxt  = MODE_HOMING;
        dir_nxt   = 1'b1;
        latch_nxt = 1'b0;
      end
      CMD_RUN: begin
        latch_nxt  = sw_l;
        steps_nxt  = '0;
        target_nxt = s1_data_r.step_target;
        mode_nxt   = MODE_RUNNING;
      end
      CMD_TICK: begin
        latch_nxt = sw_l;
        // homing: step anticlockwise until the switch latch is set
        if (mode_r == MODE_HOMING) begin
          if (!sw_l) begin
            stepped  = 1'b1;
            step_dir = dir_r;
          end else begin
            mode_nxt = MODE_OFFSET;
            dir_nxt  = 1'b0;
            ocnt_nxt = '0;
          end
        end
        // offset phase, possibly entered on this same tick
        if (mode_nxt == MODE_OFFSET) begin
          if (ocnt_nxt < offset_cfg_r) begin
            stepped  = 1'b1;
            step_dir = dir_nxt;
            ocnt_nxt = ocnt_nxt + 1'b1;
          end
          if (ocnt_nxt >= offset_cfg_r) begin
            pos_nxt  = '0;
            mode_nxt = MODE_IDLE;
          end
        end else if (mode_r == MODE_RUNNING) begin
          if (target_r == '0 || steps_r < target_r) begin
            stepped   = 1'b1;
            step_dir  = dir_r;
            steps_nxt = steps_inc;
            // traverse move with saturation at both ends
            if (!dir_r) begin
              if (pos_r != POS_MAX) pos_nxt = pos_r + 1'b1;
            end else begin
              if (pos_r != '0) pos_nxt = pos_r - 1'b1;
            end
            if (pos_nxt == '0 || pos_nxt >= loop_r) dir_nxt = !dir_r;
            if (target_r != '0 && steps_inc >= target_r) mode_nxt = MODE_IDLE;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      // unused code: only the switch latch moves
      default: latch_nxt = sw_l;
    endcase

    if (!stepped) step_dir = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      dir_r    <= 1'b0;
      pos_r    <= '0;
      steps_r  <= '0;
      target_r <= '0;
      latch_r  <= 1'b0;
      ocnt_r   <= '0;
    end else if (adv) begin
      mode_r   <= mode_nxt;
      dir_r    <= dir_nxt;
      pos_r    <= pos_nxt;
      steps_r  <= steps_nxt;
      target_r <= target_nxt;
      latch_r  <= latch_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.half_step   <= stepped;
      out_data_r.direction   <= step_dir;
      out_data_r.position    <= pos_nxt;
      out_data_r.busy_res    <= (mode_nxt != MODE_IDLE);
      out_data_r.calibrating <= (mode_nxt == MODE_HOMING) || (mode_nxt == MODE_OFFSET);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_cal_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15] |-> out_tdata[14])
    else $error("calibrating result without busy");

  a_cal_start: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (s1_cmd_r == CMD_CAL) |=> out_tvalid && !out_tdata[0] && out_tdata[1]
      && out_tdata[15])
    else $error("start calibration result wrong");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

endmodule : stepper_homing_traverse_controller_unit

`default_nettype wire

// ----- dv/tb_stepper_homing_traverse_controller_unit.sv -----
// Self-checking testbench for the stepper homing and traverse controller.
// Drives requests, APB register writes and random stalls; predicts each result.
// Depends on shtc_pkg and stepper_homing_traverse_controller_unit.
`timescale 1ns / 1ps

module tb_stepper_homing_traverse_controller_unit;
  import shtc_pkg::*;

  // Unused command code: the block must ignore it apart from the switch latch
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] target;
    logic             sw;
  } traverse_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;     // step_target[15:0], switch_seen[16], zero pad
  logic [1:0]  in_tuser = '0;     // command[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // half_step, direction, position[13:2], busy, calibrating
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  stepper_homing_traverse_controller_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stimulus backlog, results still owed, bookkeeping
  traverse_req_t req_backlog[$];
  result_t       result_due[$];
  int unsigned   queued_total = 0;
  int unsigned   mismatch_cnt = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   stall_cycles = 0;

  // Predictor copy of registers and sequencer state
  logic [POS_W-1:0] loop_len = LOOP_RESET;
  logic [POS_W-1:0] home_off_len = OFFSET_RESET;
  logic [1:0]       seq_mode = MODE_IDLE;
  logic             seq_dir = 1'b0;
  logic [POS_W-1:0] guide_pos = '0;
  logic [CNT_W-1:0] steps_taken = '0;
  logic [CNT_W-1:0] run_goal = '0;
  logic             home_latch = 1'b0;
  logic [POS_W-1:0] offset_taken = '0;

  // Advance the sequencer by one request and return the result it owes
  function automatic result_t predict_traverse(input logic [CMD_W-1:0] cmd,
                                               input logic [CNT_W-1:0] tgt,
                                               input logic sw);
    result_t r;
    logic    stepped;
    logic    step_dir;
    stepped  = 1'b0;
    step_dir = seq_dir;
    if (cmd == CMD_CAL) begin
      seq_mode   = MODE_HOMING;
      seq_dir    = 1'b1;
      home_latch = 1'b0;
    end else begin
      home_latch = home_latch | sw;
      if (cmd == CMD_RUN) begin
        steps_taken = '0;
        run_goal    = tgt;
        seq_mode    = MODE_RUNNING;
      end else if (cmd == CMD_TICK) begin
        // homing: step anticlockwise until the latch is set, then fall into offset
        if (seq_mode == MODE_HOMING) begin
          if (!home_latch) begin
            stepped  = 1'b1;
            step_dir = seq_dir;
          end else begin
            seq_mode     = MODE_OFFSET;
            seq_dir      = 1'b0;
            offset_taken = '0;
          end
        end
        if (seq_mode == MODE_OFFSET) begin
          if (offset_taken < home_off_len) begin
            stepped      = 1'b1;
            step_dir     = seq_dir;
            offset_taken = offset_taken + 1'b1;
          end
          if (offset_taken >= home_off_len) begin
            guide_pos = '0;
            seq_mode  = MODE_IDLE;
          end
        end else if (seq_mode == MODE_RUNNING) begin
          if (run_goal == '0 || steps_taken < run_goal) begin
            stepped     = 1'b1;
            step_dir    = seq_dir;
            steps_taken = steps_taken + 1'b1;
            // traverse move, saturating at both ends, reversal at 0 or the limit
            if (!seq_dir) begin
              if (guide_pos != POS_MAX) guide_pos = guide_pos + 1'b1;
            end else if (guide_pos != '0) begin
              guide_pos = guide_pos - 1'b1;
            end
            if (guide_pos == '0 || guide_pos >= loop_len) seq_dir = ~seq_dir;
            if (run_goal != '0 && steps_taken >= run_goal) seq_mode = MODE_IDLE;
          end else begin
            seq_mode = MODE_IDLE;
          end
        end
      end
    end
    if (!stepped) step_dir = seq_dir;
    r.half_step   = stepped;
    r.direction   = step_dir;
    r.position    = guide_pos;
    r.busy_res    = (seq_mode != MODE_IDLE);
    r.calibrating = (seq_mode == MODE_HOMING || seq_mode == MODE_OFFSET);
    return r;
  endfunction

  // Request driver: predicts on acceptance, loads the next request from the backlog
  always @(posedge clk) begin : req_driver
    traverse_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        result_due.push_back(predict_traverse(in_tuser, in_tdata[15:0], in_tdata[16]));
      if (!in_tvalid || in_tready) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = req_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, nxt.sw, nxt.target};
          in_tuser  <= nxt.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: field-by-field compare against the oldest prediction
  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (result_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("[%0t] unexpected result %h", $realtime, out_tdata);
        end else begin
          want = result_due.pop_front();
          if (got.half_step !== want.half_step || got.direction !== want.direction ||
              got.position !== want.position || got.busy_res !== want.busy_res ||
              got.calibrating !== want.calibrating) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("[%0t] exp step=%0d dir=%0d pos=%0d busy=%0d cal=%0d, got %0d %0d %0d %0d %0d",
                       $realtime, want.half_step, want.direction, want.position,
                       want.busy_res, want.calibrating, got.half_step, got.direction,
                       got.position, got.busy_res, got.calibrating);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] tgt,
                           input logic sw);
    traverse_req_t r;
    r.cmd = cmd;
    r.target = tgt;
    r.sw = sw;
    req_backlog.push_back(r);
    queued_total++;
  endtask

  // Wait for backlog, bus and outstanding results to empty, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_tvalid || result_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup then access; register takes the value at the access edge
  task automatic cfg_write(input logic [2:0] addr, input logic [POS_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {20'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_LOOP) loop_len = val;
    else if (addr == ADDR_OFFSET) home_off_len = val;
  endtask

  // Mostly well-formed calibrate/run sequences with random content, plus noise
  task automatic queue_random(input int unsigned n_req);
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    logic        do_run;
    logic [CNT_W-1:0] tgt;
    goal = queued_total + n_req;
    @(negedge clk);
    while (queued_total < goal) begin
      pick = $urandom_range(0, 99);
      do_run = (pick >= 40 && pick < 80);
      if (pick < 40) begin
        queue_req(CMD_CAL, 16'($urandom), 1'($urandom));
        n = $urandom_range(0, 4);
        repeat (n) queue_req(CMD_TICK, 16'($urandom), 1'b0);
        // switch edge either on a tick or carried in on an unused code
        if ($urandom_range(0, 4) == 0) begin
          queue_req(CMD_SPARE, 16'($urandom), 1'b1);
          queue_req(CMD_TICK, 16'($urandom), 1'($urandom));
        end else begin
          queue_req(CMD_TICK, 16'($urandom), 1'b1);
        end
        if (home_off_len <= 40) n = home_off_len + $urandom_range(0, 1);
        else n = $urandom_range(5, 30);
        repeat (n) queue_req(CMD_TICK, 16'($urandom), 1'($urandom));
        do_run = ($urandom_range(0, 9) < 7);
      end
      if (do_run) begin
        n = $urandom_range(0, 19);
        if (n < 3) tgt = '0;
        else if (n < 5) tgt = 16'($urandom);
        else tgt = 16'($urandom_range(1, 12));
        queue_req(CMD_RUN, tgt, 1'($urandom));
        if (tgt == '0 || tgt > 40) n = $urandom_range(3, 40);
        else n = tgt + $urandom_range(0, 2);
        repeat (n) queue_req(CMD_TICK, 16'($urandom), ($urandom_range(0, 9) == 0));
      end else if (pick >= 80) begin
        repeat ($urandom_range(1, 4)) queue_req(2'($urandom), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  // One random phase: new settings, half the traffic, full pause, the rest
  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input logic [POS_W-1:0] loop_v, input logic [POS_W-1:0] off_v);
    cfg_write(ADDR_LOOP, loop_v);
    cfg_write(ADDR_OFFSET, off_v);
    @(negedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    queue_random(100);
    wait_idle();
    queue_random(100);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short traverse and offset so every phase of the sequence shows
    cfg_write(ADDR_LOOP, 12'd3);
    cfg_write(ADDR_OFFSET, 12'd2);
    @(negedge clk);
    queue_req(CMD_TICK, 16'h0000, 1'b0);    // tick while idle
    queue_req(CMD_SPARE, 16'hFFFF, 1'b1);   // unused code sets the latch only
    queue_req(CMD_CAL, 16'hFFFF, 1'b1);     // calibrate clears the latch
    queue_req(CMD_TICK, 16'h0000, 1'b0);    // homing step
    queue_req(CMD_TICK, 16'h0000, 1'b0);
    queue_req(CMD_TICK, 16'h0000, 1'b1);    // leave home, first offset step
    queue_req(CMD_TICK, 16'hFFFF, 1'b0);    // last offset step, position zero
    queue_req(CMD_TICK, 16'h0000, 1'b0);
    queue_req(CMD_RUN, 16'h0000, 1'b0);     // unlimited run
    repeat (6) queue_req(CMD_TICK, 16'h0000, 1'b0);  // out to the limit and back to 0
    queue_req(CMD_CAL, 16'h0000, 1'b0);
    queue_req(CMD_RUN, 16'd2, 1'b0);        // keeps anticlockwise: step at 0 holds 0
    queue_req(CMD_TICK, 16'h0000, 1'b0);
    queue_req(CMD_TICK, 16'h0000, 1'b0);    // target met
    queue_req(CMD_TICK, 16'h0000, 1'b0);
    queue_req(CMD_RUN, 16'hFFFF, 1'b1);     // long run, restarted mid-run by the next request
    queue_req(CMD_RUN, 16'd1, 1'b0);
    wait_idle();

    // Directed: zero loop length and zero home offset
    cfg_write(ADDR_LOOP, 12'd0);
    cfg_write(ADDR_OFFSET, 12'd0);
    @(negedge clk);
    queue_req(CMD_CAL, 16'h0000, 1'b0);
    queue_req(CMD_TICK, 16'h0000, 1'b0);
    queue_req(CMD_SPARE, 16'h0000, 1'b1);
    queue_req(CMD_TICK, 16'h0000, 1'b0);    // calibration ends with no offset step
    queue_req(CMD_RUN, 16'd3, 1'b0);
    repeat (4) queue_req(CMD_TICK, 16'hFFFF, 1'b1);  // reverses on every step
    wait_idle();

    run_phase(33, 64, 12'd4095, 12'd1);
    run_phase(64, 33, 12'd1, 12'd4095);
    run_phase(0, 0, 12'd20, 12'd9);

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && result_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
